### design/pfb_pkg.sv
// Shared types, constants and command tables of the page frame buffer.
package pfb_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 128;
    localparam int DISPLAY_HEIGHT_DEF = 64;
    localparam int CHUNK_BYTES_DEF    = 16;

    localparam int WINDOW_CMDS = 6;
    localparam int INIT_STEPS  = 25;

    localparam logic [6:0] BUS_ADDRESS_RESET = 7'd60;

    localparam logic [7:0] CTRL_CMD      = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;

    typedef enum logic [1:0] {
        OP_PLOT  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FLUSH = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT_WB,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        WIN_COL_CMD    = 3'd0,
        WIN_COL_START  = 3'd1,
        WIN_COL_END    = 3'd2,
        WIN_PAGE_CMD   = 3'd3,
        WIN_PAGE_START = 3'd4,
        WIN_PAGE_END   = 3'd5
    } win_slot_t;

    function automatic logic [7:0] window_cmd(input logic [2:0] slot,
                                              input logic [7:0] last_col,
                                              input logic [7:0] last_page);
        logic [7:0] c;
        unique case (slot)
            WIN_COL_CMD:    c = CMD_COL_ADDR;
            WIN_COL_START:  c = 8'h00;
            WIN_COL_END:    c = last_col;
            WIN_PAGE_CMD:   c = CMD_PAGE_ADDR;
            WIN_PAGE_START: c = 8'h00;
            WIN_PAGE_END:   c = last_page;
            default:        c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] power_up_cmd(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:    c = 8'hAE;
            5'd1:    c = 8'hD5;
            5'd2:    c = 8'h80;
            5'd3:    c = 8'hA8;
            5'd4:    c = 8'h3F;
            5'd5:    c = 8'hD3;
            5'd6:    c = 8'h00;
            5'd7:    c = 8'h40;
            5'd8:    c = 8'h8D;
            5'd9:    c = 8'h14;
            5'd10:   c = 8'h20;
            5'd11:   c = 8'h00;
            5'd12:   c = 8'hA1;
            5'd13:   c = 8'hC8;
            5'd14:   c = 8'hDA;
            5'd15:   c = 8'h12;
            5'd16:   c = 8'h81;
            5'd17:   c = 8'hCF;
            5'd18:   c = 8'hD9;
            5'd19:   c = 8'hF1;
            5'd20:   c = 8'hDB;
            5'd21:   c = 8'h40;
            5'd22:   c = 8'hA4;
            5'd23:   c = 8'hA6;
            5'd24:   c = 8'hAF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### design/pfb_req_if.sv
// Request channel carrying plot, clear, flush and init items.
interface pfb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;

    modport source (output valid, output opcode, output pixel_x, output pixel_y,
                    output pixel_on, input ready);
    modport sink (input valid, input opcode, input pixel_x, input pixel_y,
                  input pixel_on, output ready);
endinterface

### design/pfb_rsp_if.sv
// Response channel carrying one bus transaction byte per item.
interface pfb_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] target_address;
    logic [7:0] tx_byte;
    logic       last_of_transaction;
    logic       sequence_done;

    modport source (output valid, output target_address, output tx_byte,
                    output last_of_transaction, output sequence_done, input ready);
    modport sink (input valid, input target_address, input tx_byte,
                  input last_of_transaction, input sequence_done, output ready);
endinterface

### design/pfb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/page_framebuffer_plot_and_flush_unit.sv
// Page-layout frame buffer with pixel plotting and a byte-run bus sequencer.
// Plot reads the store byte and then writes it back; clear zeroes every store byte.
// Flush and init steps: an accepted item loads the step, then bytes go out one
// per cycle while the response side is ready; a full data chunk is its control
// byte and CHUNK_BYTES store bytes. After reset the store is swept to zero, all
// DISPLAY_WIDTH * pages bytes (1024 by default), and no item is accepted meanwhile.
module page_framebuffer_plot_and_flush_unit #(
    parameter int DISPLAY_WIDTH  = pfb_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = pfb_pkg::DISPLAY_HEIGHT_DEF,
    parameter int CHUNK_BYTES    = pfb_pkg::CHUNK_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    pfb_req_if.sink    req,
    pfb_rsp_if.source  rsp
);

    localparam int PAGES       = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int CHUNK_COUNT = (STORE_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int FLUSH_STEPS = pfb_pkg::WINDOW_CMDS + CHUNK_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int FW          = $clog2(FLUSH_STEPS);
    localparam int LW          = $clog2(CHUNK_BYTES + 1);

    pfb_pkg::state_t state_reg, state_next;

    logic [6:0]    bus_address_reg;
    logic [AW-1:0] clr_ctr_reg, clr_ctr_next;
    logic [FW-1:0] flush_pos_reg, flush_pos_next;
    logic [4:0]    init_pos_reg, init_pos_next;

    logic [AW-1:0] plot_addr_reg;
    logic [7:0]    plot_mask_reg;
    logic          plot_on_reg;

    logic [LW-1:0] k_reg, k_next;
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    ctrl_reg, ctrl_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic          data_mode_reg, data_mode_next;
    logic          done_reg, done_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;
    logic          out_done_reg, out_done_next;

    logic          accept;
    logic          plot_in_range;
    logic [AW-1:0] plot_idx;
    logic          emit_load;
    logic          emit_last;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [FW-1:0] chunk_idx;
    logic [31:0]   chunk_base;
    logic [31:0]   chunk_remain;
    logic [LW-1:0] chunk_len;

    assign plot_in_range = (9'(req.pixel_x) < 9'(DISPLAY_WIDTH))
                        && (9'(req.pixel_y) < 9'(DISPLAY_HEIGHT));
    assign plot_idx = AW'(32'(req.pixel_x) + 32'(req.pixel_y[7:3]) * 32'(DISPLAY_WIDTH));

    assign chunk_idx    = flush_pos_reg - FW'(pfb_pkg::WINDOW_CMDS);
    assign chunk_base   = 32'(chunk_idx) * 32'(CHUNK_BYTES);
    assign chunk_remain = 32'(STORE_BYTES) - chunk_base;
    assign chunk_len    = (chunk_remain < 32'(CHUNK_BYTES)) ? LW'(chunk_remain)
                                                            : LW'(CHUNK_BYTES);

    assign emit_last = (k_reg == len_reg);

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfb_pkg::ST_CLEAR:
            begin
                if (clr_ctr_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
            pfb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (pfb_pkg::op_t'(req.opcode))
                        pfb_pkg::OP_PLOT:
                            state_next = plot_in_range ? pfb_pkg::ST_PLOT_WB : pfb_pkg::ST_IDLE;
                        pfb_pkg::OP_CLEAR: state_next = pfb_pkg::ST_CLEAR;
                        pfb_pkg::OP_FLUSH: state_next = pfb_pkg::ST_EMIT;
                        pfb_pkg::OP_INIT:  state_next = pfb_pkg::ST_EMIT;
                    endcase
                end
            end
            pfb_pkg::ST_PLOT_WB:
                state_next = pfb_pkg::ST_IDLE;
            pfb_pkg::ST_EMIT:
            begin
                if (emit_load && emit_last)
                begin
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == pfb_pkg::ST_IDLE);
        emit_load = (state_reg == pfb_pkg::ST_EMIT) && (!out_valid_reg || rsp.ready);
        ram_we    = (state_reg == pfb_pkg::ST_CLEAR) || (state_reg == pfb_pkg::ST_PLOT_WB);
        ram_waddr = (state_reg == pfb_pkg::ST_CLEAR) ? clr_ctr_reg : plot_addr_reg;
        ram_wdata = '0;
        if (state_reg == pfb_pkg::ST_PLOT_WB)
        begin
            ram_wdata = plot_on_reg ? (ram_rdata | plot_mask_reg)
                                    : (ram_rdata & ~plot_mask_reg);
        end
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;
        if (state_reg == pfb_pkg::ST_IDLE)
        begin
            ram_raddr = plot_idx;
            ram_re    = req.valid && (pfb_pkg::op_t'(req.opcode) == pfb_pkg::OP_PLOT)
                     && plot_in_range;
        end
        else if (emit_load && data_mode_reg)
        begin
            ram_re = 1'b1;
        end
    end

    assign accept = req.valid && req.ready;

    always_comb
    begin
        clr_ctr_next   = (state_reg == pfb_pkg::ST_CLEAR) ? clr_ctr_reg + 1'b1 : '0;
        flush_pos_next = flush_pos_reg;
        init_pos_next  = init_pos_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        ctrl_next      = ctrl_reg;
        cmd_next       = cmd_reg;
        data_mode_next = data_mode_reg;
        done_next      = done_reg;
        rd_addr_next   = rd_addr_reg;

        if (accept && (pfb_pkg::op_t'(req.opcode) == pfb_pkg::OP_FLUSH))
        begin
            k_next    = '0;
            done_next = (flush_pos_reg == FW'(FLUSH_STEPS - 1));
            flush_pos_next = (flush_pos_reg == FW'(FLUSH_STEPS - 1)) ? '0
                                                                     : flush_pos_reg + 1'b1;
            if (flush_pos_reg < FW'(pfb_pkg::WINDOW_CMDS))
            begin
                ctrl_next      = pfb_pkg::CTRL_CMD;
                cmd_next       = pfb_pkg::window_cmd(flush_pos_reg[2:0],
                                                     8'(DISPLAY_WIDTH - 1), 8'(PAGES - 1));
                len_next       = LW'(1);
                data_mode_next = 1'b0;
            end
            else
            begin
                ctrl_next      = pfb_pkg::CTRL_DATA;
                len_next       = chunk_len;
                data_mode_next = 1'b1;
                rd_addr_next   = AW'(chunk_base);
            end
        end
        else if (accept && (pfb_pkg::op_t'(req.opcode) == pfb_pkg::OP_INIT))
        begin
            k_next         = '0;
            done_next      = (init_pos_reg == 5'(pfb_pkg::INIT_STEPS - 1));
            init_pos_next  = (init_pos_reg == 5'(pfb_pkg::INIT_STEPS - 1)) ? '0
                                                                         : init_pos_reg + 1'b1;
            ctrl_next      = pfb_pkg::CTRL_CMD;
            cmd_next       = pfb_pkg::power_up_cmd(init_pos_reg);
            len_next       = LW'(1);
            data_mode_next = 1'b0;
        end
        else if (emit_load)
        begin
            k_next       = k_reg + 1'b1;
            rd_addr_next = rd_addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = emit_last;
            out_done_next  = done_reg;
            if (k_reg == '0)
            begin
                out_byte_next = ctrl_reg;
            end
            else
            begin
                out_byte_next = data_mode_reg ? ram_rdata : cmd_reg;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pfb_pkg::ST_CLEAR;
            bus_address_reg <= pfb_pkg::BUS_ADDRESS_RESET;
            clr_ctr_reg     <= '0;
            flush_pos_reg   <= '0;
            init_pos_reg    <= '0;
            k_reg           <= '0;
            len_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ctr_reg   <= clr_ctr_next;
            flush_pos_reg <= flush_pos_next;
            init_pos_reg  <= init_pos_next;
            k_reg         <= k_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                bus_address_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg      <= ctrl_next;
        cmd_reg       <= cmd_next;
        data_mode_reg <= data_mode_next;
        done_reg      <= done_next;
        rd_addr_reg   <= rd_addr_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
        if (accept)
        begin
            plot_addr_reg <= plot_idx;
            plot_mask_reg <= 8'(1) << req.pixel_y[2:0];
            plot_on_reg   <= req.pixel_on;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.target_address      = bus_address_reg;
    assign rsp.tx_byte             = out_byte_reg;
    assign rsp.last_of_transaction = out_last_reg;
    assign rsp.sequence_done       = out_done_reg;

`ifndef SYNTHESIS
    a_no_read_during_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("Frame store read and write in the same cycle.");

    a_byte_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfb_pkg::ST_EMIT) |-> (k_reg <= len_reg))
        else $error("Transaction byte counter ran past the transaction length.");

    a_last_byte_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && emit_last) |=> (state_reg == pfb_pkg::ST_IDLE) && out_last_reg)
        else $error("Final transaction byte did not close the run.");

    a_flush_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(flush_pos_reg) < 32'(FLUSH_STEPS))
        else $error("Flush position beyond the end of the sequence.");
`endif

endmodule

### dv/pfb_byte_run_checker.sv
// Checker that predicts the bus byte runs and compares them with the response channel.
`timescale 1ns / 1ps

module pfb_byte_run_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    pfb_req_if         req,
    pfb_rsp_if         rsp,
    output int         mismatch_count,
    output int         bytes_outstanding
);

    localparam int WIDTH       = pfb_pkg::DISPLAY_WIDTH_DEF;
    localparam int HEIGHT      = pfb_pkg::DISPLAY_HEIGHT_DEF;
    localparam int CHUNK       = pfb_pkg::CHUNK_BYTES_DEF;
    localparam int PAGES       = (HEIGHT + 7) / 8;
    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int CHUNK_COUNT = (STORE_BYTES + CHUNK - 1) / CHUNK;
    localparam int FLUSH_STEPS = pfb_pkg::WINDOW_CMDS + CHUNK_COUNT;

    typedef struct packed {
        logic [6:0] addr;
        logic [7:0] data;
        logic       last;
        logic       done;
    } bus_byte_t;

    logic [7:0] power_up_seq [pfb_pkg::INIT_STEPS] = '{
        8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'h8D, 8'h14,
        8'h20, 8'h00, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9, 8'hF1,
        8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
    };

    bus_byte_t  expected_bytes [$];
    logic [7:0] pixels [STORE_BYTES];
    logic [6:0] dev_addr;
    int         flush_step;
    int         init_step;
    int         fails;

    function automatic void push_byte(input logic [7:0] b, input logic last, input logic done);
        bus_byte_t e;
        e.addr = dev_addr;
        e.data = b;
        e.last = last;
        e.done = done;
        expected_bytes.push_back(e);
    endfunction

    function automatic void push_command(input logic [7:0] c, input logic done);
        push_byte(pfb_pkg::CTRL_CMD, 1'b0, done);
        push_byte(c, 1'b1, done);
    endfunction

    function automatic void apply_request(input pfb_pkg::op_t op, input logic [7:0] x,
                                          input logic [7:0] y, input logic on);
        int         idx;
        int         base;
        int         len;
        logic       done;
        logic [7:0] c;
        case (op)
            pfb_pkg::OP_PLOT:
            begin
                if (x < WIDTH && y < HEIGHT)
                begin
                    idx = x + (y / 8) * WIDTH;
                    pixels[idx][y[2:0]] = on;
                end
            end
            pfb_pkg::OP_CLEAR:
            begin
                foreach (pixels[i])
                begin
                    pixels[i] = '0;
                end
            end
            pfb_pkg::OP_FLUSH:
            begin
                done = (flush_step == FLUSH_STEPS - 1);
                if (flush_step < pfb_pkg::WINDOW_CMDS)
                begin
                    case (flush_step)
                        pfb_pkg::WIN_COL_CMD:    c = pfb_pkg::CMD_COL_ADDR;
                        pfb_pkg::WIN_COL_START:  c = 8'h00;
                        pfb_pkg::WIN_COL_END:    c = 8'(WIDTH - 1);
                        pfb_pkg::WIN_PAGE_CMD:   c = pfb_pkg::CMD_PAGE_ADDR;
                        pfb_pkg::WIN_PAGE_START: c = 8'h00;
                        default:                 c = 8'(PAGES - 1);
                    endcase
                    push_command(c, done);
                end
                else
                begin
                    base = (flush_step - pfb_pkg::WINDOW_CMDS) * CHUNK;
                    len  = (base + CHUNK > STORE_BYTES) ? STORE_BYTES - base : CHUNK;
                    push_byte(pfb_pkg::CTRL_DATA, len == 0, done);
                    for (int i = 0; i < len; i++)
                    begin
                        push_byte(pixels[base + i], i + 1 == len, done);
                    end
                end
                flush_step = (flush_step + 1 >= FLUSH_STEPS) ? 0 : flush_step + 1;
            end
            default:
            begin
                push_command(power_up_seq[init_step], init_step == pfb_pkg::INIT_STEPS - 1);
                init_step = (init_step + 1 >= pfb_pkg::INIT_STEPS) ? 0 : init_step + 1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bus_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            foreach (pixels[i])
            begin
                pixels[i] = '0;
            end
            dev_addr   = pfb_pkg::BUS_ADDRESS_RESET;
            flush_step = 0;
            init_step  = 0;
            fails      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("tx_byte: expected none, got %0d", rsp.tx_byte);
                    fails++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    check_field("target_address", want.addr, rsp.target_address);
                    check_field("tx_byte", want.data, rsp.tx_byte);
                    check_field("last_of_transaction", want.last, rsp.last_of_transaction);
                    check_field("sequence_done", want.done, rsp.sequence_done);
                end
            end
            if (req.valid && req.ready)
            begin
                apply_request(pfb_pkg::op_t'(req.opcode), req.pixel_x, req.pixel_y,
                              req.pixel_on);
            end
            if (cfg_wr_en)
            begin
                dev_addr = cfg_wr_data;
            end
        end
        mismatch_count    <= fails;
        bytes_outstanding <= expected_bytes.size();
    end

endmodule

### dv/tb_page_framebuffer_plot_and_flush_unit.sv
// Testbench top: drives plot, clear, flush, init and address items and gives the verdict.
`timescale 1ns / 1ps

module tb_page_framebuffer_plot_and_flush_unit;

    localparam int DRAIN_CYCLES = 1100;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_CYCLES  = 400;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [6:0] cfg_wr_data;
    int         mismatch_count;
    int         bytes_outstanding;
    int         send_calm;
    int         take_calm;

    pfb_req_if req ();
    pfb_rsp_if rsp ();

    page_framebuffer_plot_and_flush_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp)
    );

    pfb_byte_run_checker byte_run_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .req               (req),
        .rsp               (rsp),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    task automatic send_item(input pfb_pkg::op_t op, input logic [7:0] x,
                             input logic [7:0] y, input logic on);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.opcode   <= op;
        req.pixel_x  <= x;
        req.pixel_y  <= y;
        req.pixel_on <= on;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic send_random_item();
        int           r;
        pfb_pkg::op_t op;
        logic [7:0]   x;
        logic [7:0]   y;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = pfb_pkg::OP_PLOT;
        else if (r < 85)
            op = pfb_pkg::OP_FLUSH;
        else if (r < 97)
            op = pfb_pkg::OP_INIT;
        else
            op = pfb_pkg::OP_CLEAR;
        x = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255));
        y = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 255));
        send_item(op, x, y, $urandom_range(0, 3) != 0);
    endtask

    // A clear yields no bytes but keeps the block busy, so the write waits it out.
    task automatic set_address(input logic [6:0] a);
        req.valid <= 1'b0;
        while (bytes_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int bytes_taken;
        int gap;
        bit held_off;
        bytes_taken = 0;
        held_off    = 1'b0;
        take_calm   = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            if (!held_off && bytes_taken >= 150)
            begin
                held_off = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = pick_gap(take_calm);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            bytes_taken++;
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        send_calm = 0;
        rst_n = 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        req.valid    <= 1'b0;
        req.opcode   <= pfb_pkg::OP_PLOT;
        req.pixel_x  <= '0;
        req.pixel_y  <= '0;
        req.pixel_on <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, still at the reset address.
        send_item(pfb_pkg::OP_INIT, 8'hFF, 8'hFF, 1'b1);
        send_item(pfb_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b0);
        send_item(pfb_pkg::OP_PLOT, 8'd0, 8'd0, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd127, 8'd63, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd127, 8'd0, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd0, 8'd63, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd128, 8'd5, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd5, 8'd64, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd255, 8'd255, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd255, 8'd255, 1'b0);
        send_item(pfb_pkg::OP_PLOT, 8'd127, 8'd63, 1'b0);
        send_item(pfb_pkg::OP_PLOT, 8'd127, 8'd63, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd64, 8'd7, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd64, 8'd8, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd0, 8'd0, 1'b0);
        send_item(pfb_pkg::OP_CLEAR, 8'hAA, 8'h55, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd3, 8'd9, 1'b1);
        send_item(pfb_pkg::OP_PLOT, 8'd15, 8'd1, 1'b1);
        for (int i = 0; i < 6; i++)
        begin
            send_item(pfb_pkg::OP_FLUSH, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'b0);
        end

        set_address(7'd0);
        repeat (PHASE_ITEMS) send_random_item();
        set_address(7'd127);
        repeat (PHASE_ITEMS) send_random_item();
        set_address(7'($urandom_range(1, 126)));
        repeat (PHASE_ITEMS) send_random_item();
        set_address(7'($urandom_range(1, 126)));
        repeat (PHASE_ITEMS) send_random_item();

        req.valid <= 1'b0;
        while (bytes_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/pfb_pkg.sv
design/pfb_req_if.sv
design/pfb_rsp_if.sv
design/pfb_ram.sv
design/page_framebuffer_plot_and_flush_unit.sv
dv/pfb_byte_run_checker.sv
dv/tb_page_framebuffer_plot_and_flush_unit.sv
